// ----- src/snm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snm_pkg: shared types and constants
// Payload structs, limit bundle and queue sizing for the nearest-match block.
// ----------------------------------------------------------------------------
package snm_pkg;

  localparam int ELEM_W     = 16;
  localparam int DIFF_W     = ELEM_W + 1;
  localparam int SQ_W       = 2 * ELEM_W + 1;
  localparam int DIST_W     = 48;
  localparam int POS_W      = 11;
  localparam int LEN_W      = 9;
  localparam int QADDR_W    = 8;
  localparam int DESC_DEPTH = 256;
  localparam int MAX_DIM    = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = POS_W;

  localparam int MQ_DEPTH   = 4;
  localparam int MQ_CW      = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // request operation codes
  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_MAP   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DESC_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd2;

  typedef struct packed {
    logic                     func;
    logic [QADDR_W-1:0]       elem_index;
    logic signed [ELEM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [DIST_W-1:0] best_dist;
    logic [POS_W-1:0]  best_col;
    logic [POS_W-1:0]  best_row;
    logic              frame_last;
  } res_item_t;

  // element difference handed from the front to the back
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic                     last;
  } mid_item_t;

  // clamped configuration limits
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] w;
    logic [POS_W-1:0] h;
  } cfg_lim_t;

endpackage
`default_nettype wire

// ----- src/snm_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snm_fifo: small register queue
// First-in first-out store; head entry shown while count is nonzero.
// ----------------------------------------------------------------------------
module snm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [WIDTH-1:0]               din,
  input  wire logic                           pop,
  output logic      [WIDTH-1:0]               dout,
  output logic      [$clog2(DEPTH + 1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign dout = mem[rd_ptr];

endmodule
`default_nettype wire

// ----- src/snm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snm_front: request intake
// Stores query elements, reads the matching query element for each map
// element, tracks descriptor boundaries and forwards differences.
// ----------------------------------------------------------------------------
module snm_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire snm_pkg::in_item_t     item,
  input  wire snm_pkg::cfg_lim_t     lim,
  input  wire logic [snm_pkg::MQ_CW-1:0] mq_count,
  output logic                       mq_push,
  output snm_pkg::mid_item_t         mq_din
);

  logic signed [snm_pkg::ELEM_W-1:0] qmem [snm_pkg::DESC_DEPTH];
  logic [snm_pkg::QADDR_W-1:0]       elem_cnt;
  logic                              f_valid;
  logic signed [snm_pkg::ELEM_W-1:0] f_q;
  logic signed [snm_pkg::ELEM_W-1:0] f_v;
  logic                              f_last;
  logic                              accept;
  logic                              last_elem;
  logic [snm_pkg::MQ_CW:0]           mq_used;

  // the staged element always has a reserved slot in the queue
  assign mq_used   = {1'b0, mq_count} + (snm_pkg::MQ_CW + 1)'(f_valid);
  assign full      = mq_used >= (snm_pkg::MQ_CW + 1)'(snm_pkg::MQ_DEPTH);
  assign accept    = push && !full;
  assign last_elem = ({1'b0, elem_cnt} + snm_pkg::LEN_W'(1)) >= lim.len;

  always_ff @(posedge clk) begin
    if (accept && item.func == snm_pkg::FUNC_QUERY) begin
      qmem[item.elem_index] <= item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.func == snm_pkg::FUNC_MAP) begin
      f_q    <= qmem[elem_cnt];
      f_v    <= item.value;
      f_last <= last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt <= '0;
      f_valid  <= 1'b0;
    end else begin
      f_valid <= accept && item.func == snm_pkg::FUNC_MAP;
      if (accept && item.func == snm_pkg::FUNC_MAP) begin
        elem_cnt <= last_elem ? '0 : elem_cnt + 1'b1;
      end
    end
  end

  assign mq_push     = f_valid;
  assign mq_din.diff = {f_v[snm_pkg::ELEM_W-1], f_v} - {f_q[snm_pkg::ELEM_W-1], f_q};
  assign mq_din.last = f_last;

  a_mq_room: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (mq_count < snm_pkg::MQ_CW'(snm_pkg::MQ_DEPTH)))
    else $error("mid queue push without room");

endmodule
`default_nettype wire

// ----- src/snm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snm_back: distance datapath
// Squares differences, accumulates with saturation, tracks the running
// minimum and map position, and pushes one result per descriptor.
// ----------------------------------------------------------------------------
module snm_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [snm_pkg::MQ_CW-1:0] mq_count,
  input  wire snm_pkg::mid_item_t        mq_dout,
  output logic                           mq_pop,
  input  wire snm_pkg::cfg_lim_t         lim,
  input  wire logic [snm_pkg::OQ_CW-1:0] oq_count,
  output logic                           oq_push,
  output snm_pkg::res_item_t             oq_din
);

  localparam int SQ_W   = snm_pkg::SQ_W;
  localparam int DIST_W = snm_pkg::DIST_W;
  localparam int POS_W  = snm_pkg::POS_W;
  localparam int CW     = snm_pkg::OQ_CW;

  logic [CW:0]                 inflight;
  logic [snm_pkg::DIFF_W-1:0]  mag;
  logic [SQ_W-1:0]             prod;
  logic                        s1_valid;
  logic                        s1_last;
  logic [SQ_W-1:0]             s1_sq;
  logic [DIST_W-1:0]           acc;
  logic [DIST_W:0]             sum;
  logic [DIST_W-1:0]           acc_new;
  logic                        s2_valid;
  logic [DIST_W-1:0]           s2_dist;
  logic [POS_W-1:0]            col_cnt;
  logic [POS_W-1:0]            row_cnt;
  logic [DIST_W-1:0]           best_d;
  logic [POS_W-1:0]            best_c;
  logic [POS_W-1:0]            best_r;
  logic                        better;
  logic                        last;

  // pop only when every result that could be in flight has a slot
  assign inflight = {1'b0, oq_count} + (CW + 1)'(s1_valid) + (CW + 1)'(s2_valid);
  assign mq_pop   = (mq_count != '0) && (inflight < (CW + 1)'(snm_pkg::OQ_DEPTH));

  assign mag  = mq_dout.diff[snm_pkg::DIFF_W-1] ? snm_pkg::DIFF_W'(-mq_dout.diff)
                                                : snm_pkg::DIFF_W'(mq_dout.diff);
  assign prod = SQ_W'(mag) * SQ_W'(mag);

  assign sum     = {1'b0, acc} + (DIST_W + 1)'(s1_sq);
  assign acc_new = (sum >= {1'b0, snm_pkg::DIST_MAX}) ? snm_pkg::DIST_MAX
                                                      : sum[DIST_W-1:0];

  assign better = s2_dist < best_d;
  assign last   = (col_cnt >= lim.w) && (row_cnt >= lim.h);

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      s1_sq   <= prod;
      s1_last <= mq_dout.last;
    end
    if (s1_valid && s1_last) begin
      s2_dist <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc      <= '0;
      col_cnt  <= POS_W'(1);
      row_cnt  <= POS_W'(1);
      best_d   <= snm_pkg::DIST_MAX;
      best_c   <= '0;
      best_r   <= '0;
    end else begin
      s1_valid <= mq_pop;
      s2_valid <= s1_valid && s1_last;
      if (s1_valid) begin
        acc <= s1_last ? '0 : acc_new;
      end
      if (s2_valid) begin
        if (last) begin
          col_cnt <= POS_W'(1);
          row_cnt <= POS_W'(1);
          best_d  <= snm_pkg::DIST_MAX;
          best_c  <= '0;
          best_r  <= '0;
        end else begin
          if (col_cnt >= lim.w) begin
            col_cnt <= POS_W'(1);
            row_cnt <= row_cnt + 1'b1;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
          if (better) begin
            best_d <= s2_dist;
            best_c <= col_cnt;
            best_r <= row_cnt;
          end
        end
      end
    end
  end

  assign oq_push           = s2_valid;
  assign oq_din.sq_dist    = s2_dist;
  assign oq_din.col        = col_cnt;
  assign oq_din.row        = row_cnt;
  assign oq_din.best_dist  = better ? s2_dist : best_d;
  assign oq_din.best_col   = better ? col_cnt : best_c;
  assign oq_din.best_row   = better ? row_cnt : best_r;
  assign oq_din.frame_last = last;

  a_oq_room: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> (oq_count < CW'(snm_pkg::OQ_DEPTH)))
    else $error("result queue push without room");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid && s1_last))
    else $error("result without a closing element");

  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !last) |=> (best_d <= $past(best_d)))
    else $error("running minimum grew inside a frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && last) |=> (col_cnt == POS_W'(1) && row_cnt == POS_W'(1) && best_c == '0))
    else $error("frame did not restart");

endmodule
`default_nettype wire

// ----- src/sq_euclid_nearest_match.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sq_euclid_nearest_match: brute-force nearest descriptor search
// Squared Euclidean distance of a stored query against every map descriptor,
// with running minimum and its position.
//
//   channel   handshake            payload
//   -------   ------------------   --------------------------------------
//   input     push / full          item   (func, elem_index, value)
//   result    empty / pop          result (distance, position, minimum)
//   config    cfg_write            cfg_index, cfg_data (no read-back)
//
// One request is taken every cycle while full is low; the two-stage
// square/accumulate path feeds the running-minimum update.
// A result passes the staging register, the mid queue, stages s1 and s2
// and the output queue before it reaches the ports.
// Four-entry queues sit between intake and datapath and at the output;
// full rises only when the mid queue and staged element lack room.
// Synchronous reset; the query store holds no reset value.
// ----------------------------------------------------------------------------
module sq_euclid_nearest_match (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire snm_pkg::in_item_t              item,
  output logic                                empty,
  input  wire logic                           pop,
  output snm_pkg::res_item_t                  result,
  input  wire logic                           cfg_write,
  input  wire logic [snm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [snm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W = snm_pkg::LEN_W;
  localparam int POS_W = snm_pkg::POS_W;
  localparam int MQ_W  = $bits(snm_pkg::mid_item_t);
  localparam int OQ_W  = $bits(snm_pkg::res_item_t);

  snm_pkg::cfg_lim_t          lim;
  logic                       mq_push;
  logic                       mq_pop;
  snm_pkg::mid_item_t         mq_din;
  logic [MQ_W-1:0]            mq_dout;
  logic [snm_pkg::MQ_CW-1:0]  mq_count;
  logic                       oq_push;
  snm_pkg::res_item_t         oq_din;
  logic [OQ_W-1:0]            oq_dout;
  logic [snm_pkg::OQ_CW-1:0]  oq_count;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    if (v == '0) return LEN_W'(1);
    if (v > LEN_W'(snm_pkg::DESC_DEPTH)) return LEN_W'(snm_pkg::DESC_DEPTH);
    return v;
  endfunction

  function automatic logic [POS_W-1:0] clamp_dim(input logic [POS_W-1:0] v);
    if (v == '0) return POS_W'(1);
    if (v > POS_W'(snm_pkg::MAX_DIM)) return POS_W'(snm_pkg::MAX_DIM);
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.len <= LEN_W'(200);
      lim.w   <= POS_W'(1);
      lim.h   <= POS_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        snm_pkg::REG_DESC_LEN:   lim.len <= clamp_len(cfg_data[LEN_W-1:0]);
        snm_pkg::REG_MAP_WIDTH:  lim.w   <= clamp_dim(cfg_data);
        snm_pkg::REG_MAP_HEIGHT: lim.h   <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  snm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .lim      (lim),
    .mq_count (mq_count),
    .mq_push  (mq_push),
    .mq_din   (mq_din)
  );

  snm_fifo #(
    .WIDTH (MQ_W),
    .DEPTH (snm_pkg::MQ_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .din   (mq_din),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .count (mq_count)
  );

  snm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mq_count (mq_count),
    .mq_dout  (snm_pkg::mid_item_t'(mq_dout)),
    .mq_pop   (mq_pop),
    .lim      (lim),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_din   (oq_din)
  );

  snm_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (snm_pkg::OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .din   (oq_din),
    .pop   (pop && !empty),
    .dout  (oq_dout),
    .count (oq_count)
  );

  assign empty  = (oq_count == '0);
  assign result = snm_pkg::res_item_t'(oq_dout);

endmodule
`default_nettype wire
